// ===== design/kvts_pkg.sv =====
// package for the keyframe vector track sampler: types, constants, sequencer states
`timescale 1ns / 1ps
package kvts_pkg;
    localparam int MAX_KEYS_DEF        = 64;
    localparam int RATIO_FRAC_BITS_DEF = 16;
    localparam logic [31:0] ONE_Q16    = 32'h0001_0000;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PREV,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } state_t;

    // request from sequencer to the divider
    typedef struct packed {
        logic start;
    } div_ctl_t;
endpackage

// ===== design/kvts_div.sv =====
// restoring divider, one quotient bit per cycle, clamps ratio to one
`timescale 1ns / 1ps
module kvts_div #(
    parameter int RATIO_FRAC_BITS = kvts_pkg::RATIO_FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  kvts_pkg::div_ctl_t         ctl,
    input  logic [32:0]                cur,
    input  logic [32:0]                span,
    output logic                       busy,
    output logic [RATIO_FRAC_BITS:0]   ratio
);
    localparam int NB = 33 + RATIO_FRAC_BITS;
    localparam int CW = $clog2(NB + 1);

    logic [NB-1:0] num_reg, num_next;
    logic [33:0]   rem_reg, rem_next;
    logic [NB-1:0] quo_reg, quo_next;
    logic [32:0]   den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [33:0]   shifted;

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        shifted   = {rem_reg[32:0], num_reg[NB-1]};
        if (ctl.start)
        begin
            num_next  = {cur, {RATIO_FRAC_BITS{1'b0}}};
            rem_next  = '0;
            quo_next  = '0;
            den_next  = span;
            cnt_next  = CW'(NB);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = num_reg << 1;
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = shifted - {1'b0, den_reg};
                quo_next = {quo_reg[NB-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[NB-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    // clamp to one
    assign ratio = (quo_reg > NB'({1'b1, {RATIO_FRAC_BITS{1'b0}}})) ?
                   {1'b1, {RATIO_FRAC_BITS{1'b0}}} : quo_reg[RATIO_FRAC_BITS:0];
endmodule

// ===== design/kvts_lerp.sv =====
// shared multiply-add: prev + floor(diff * r >> frac), with diff and prev registered
`timescale 1ns / 1ps
module kvts_lerp #(
    parameter int RATIO_FRAC_BITS = kvts_pkg::RATIO_FRAC_BITS_DEF
) (
    input  logic                     clk,
    input  logic signed [31:0]       a,
    input  logic signed [31:0]       b,
    input  logic [RATIO_FRAC_BITS:0] ratio,
    output logic signed [31:0]       y
);
    localparam int PW = 34 + RATIO_FRAC_BITS;

    logic signed [32:0] diff_reg;
    logic signed [31:0] a_reg;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] sh;

    always_ff @(posedge clk)
    begin
        diff_reg <= 33'(b) - 33'(a);
        a_reg    <= a;
    end

    assign prod = PW'(diff_reg) * $signed({1'b0, ratio});
    // arithmetic shift is a floor
    assign sh   = prod >>> RATIO_FRAC_BITS;
    assign y    = a_reg + sh[31:0];
endmodule

// ===== design/keyframe_vector_track_sampler.sv =====
// top level: key table, scan sequencer, divider and shared multiply-add
//
//  channel  signals                                         dir
//  input    valid ready cmd key_time value_x value_y value_z  in
//  result   out_valid out_ready out_x out_y out_z status       out
//  config   cfg_valid cfg_ready track_kind                     in
//
// append and clear pass through the done state before raising their result; a
// query scans the keys in order, a table read and a check per key, until it
// finds one at or after the query time, then reads the previous key, runs the
// bit-serial divider and three multiply-adds, one per component, and raises
// the result. reset empties the table and sets track_kind to position.
// the block holds ready low while an item is in work or a result waits.
`timescale 1ns / 1ps
module keyframe_vector_track_sampler #(
    parameter int MAX_KEYS        = kvts_pkg::MAX_KEYS_DEF,
    parameter int RATIO_FRAC_BITS = kvts_pkg::RATIO_FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    output logic               ready,
    input  logic [1:0]         cmd,
    input  logic [31:0]        key_time,
    input  logic signed [31:0] value_x,
    input  logic signed [31:0] value_y,
    input  logic signed [31:0] value_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic               status,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               track_kind
);
    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW = $clog2(MAX_KEYS + 1);

    logic [127:0] mem [MAX_KEYS];
    logic [127:0] rd_reg;

    kvts_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [1:0]    comp_reg, comp_next;
    logic          kind_reg;
    logic [31:0]   t_reg;
    logic [127:0]  nxt_reg, prv_reg;
    logic          found_next;
    logic signed [31:0] ox_reg, oy_reg, oz_reg;
    logic          st_reg;
    logic          ovalid_reg;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic          sub_cycle_reg;
    kvts_pkg::div_ctl_t dctl;
    logic          dbusy;
    logic [RATIO_FRAC_BITS:0] ratio, ratio_use;
    logic [31:0]   prev_t;
    logic signed [32:0] span, cur;
    logic          use_one;
    logic signed [31:0] la, lb, ly;

    assign ready     = (state_reg == kvts_pkg::ST_IDLE) && !ovalid_reg;
    assign cfg_ready = 1'b1;
    wire accept = valid && ready;

    // memory
    assign wr_en = accept && (cmd == kvts_pkg::CMD_APPEND) && (count_reg < CW'(MAX_KEYS));
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[count_reg[AW-1:0]] <= {key_time, value_x, value_y, value_z};
        if (rd_en)
            rd_reg <= mem[rd_addr];
    end

    // during the neighbor read the previous key sits in rd_reg, not yet in prv_reg
    assign prev_t = (state_reg == kvts_pkg::ST_PREV) ? rd_reg[127:96] : prv_reg[127:96];
    assign span = $signed({1'b0, nxt_reg[127:96]}) - $signed({1'b0, prev_t});
    assign cur  = $signed({1'b0, t_reg}) - $signed({1'b0, prev_t});
    assign use_one = (span <= 0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kvts_pkg::ST_IDLE:
                if (accept && cmd == kvts_pkg::CMD_QUERY)
                    state_next = kvts_pkg::ST_SCAN;
                else if (accept)
                    state_next = kvts_pkg::ST_DONE;
            kvts_pkg::ST_SCAN:
                if (sub_cycle_reg && (found_next || idx_reg >= count_reg))
                    state_next = found_next ? kvts_pkg::ST_PREV : kvts_pkg::ST_DONE;
            kvts_pkg::ST_PREV:
                if (sub_cycle_reg)
                    state_next = kvts_pkg::ST_DIV;
            kvts_pkg::ST_DIV:
                if (sub_cycle_reg && !dbusy)
                    state_next = kvts_pkg::ST_MUL;
            kvts_pkg::ST_MUL:
                if (sub_cycle_reg && comp_reg == 2'd2)
                    state_next = kvts_pkg::ST_DONE;
            kvts_pkg::ST_DONE:
                state_next = kvts_pkg::ST_IDLE;
            default:
                state_next = kvts_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        rd_en      = 1'b0;
        rd_addr    = idx_reg[AW-1:0];
        idx_next   = idx_reg;
        comp_next  = comp_reg;
        found_next = 1'b0;
        dctl.start = 1'b0;
        count_next = count_reg;
        case (state_reg)
            kvts_pkg::ST_IDLE:
            begin
                idx_next  = '0;
                comp_next = '0;
                if (wr_en)
                    count_next = count_reg + 1'b1;
                if (accept && cmd == kvts_pkg::CMD_CLEAR)
                    count_next = '0;
            end
            kvts_pkg::ST_SCAN:
            begin
                // even cycle issues read, odd cycle checks it
                if (!sub_cycle_reg)
                    rd_en = (idx_reg < count_reg);
                else
                begin
                    found_next = (idx_reg < count_reg) && (rd_reg[127:96] >= t_reg);
                    if (!found_next)
                        idx_next = idx_reg + 1'b1;
                end
            end
            kvts_pkg::ST_PREV:
            begin
                rd_en   = !sub_cycle_reg;
                rd_addr = (idx_reg == '0) ? '0 : AW'(idx_reg - 1'b1);
                if (sub_cycle_reg)
                    dctl.start = 1'b1;
            end
            kvts_pkg::ST_DIV: ;
            kvts_pkg::ST_MUL:
                if (sub_cycle_reg)
                    comp_next = comp_reg + 1'b1;
            kvts_pkg::ST_DONE: ;
            default: ;
        endcase
    end

    kvts_div #(.RATIO_FRAC_BITS(RATIO_FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (dctl),
        .cur   (cur[32] ? 33'd0 : cur),
        .span  (span),
        .busy  (dbusy),
        .ratio (ratio)
    );

    assign ratio_use = use_one ? {1'b1, {RATIO_FRAC_BITS{1'b0}}} :
                       (cur <= 0) ? '0 : ratio;

    always_comb
    begin
        case (comp_reg)
            2'd0:    begin la = prv_reg[95:64]; lb = nxt_reg[95:64]; end
            2'd1:    begin la = prv_reg[63:32]; lb = nxt_reg[63:32]; end
            default: begin la = prv_reg[31:0];  lb = nxt_reg[31:0];  end
        endcase
    end

    kvts_lerp #(.RATIO_FRAC_BITS(RATIO_FRAC_BITS)) u_lerp (
        .clk   (clk),
        .a     (la),
        .b     (lb),
        .ratio (ratio_use),
        .y     (ly)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kvts_pkg::ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            comp_reg      <= '0;
            kind_reg      <= 1'b0;
            ovalid_reg    <= 1'b0;
            sub_cycle_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            comp_reg   <= comp_next;
            if (cfg_valid && cfg_ready)
                kind_reg <= track_kind;
            sub_cycle_reg <= (state_next == state_reg) ? !sub_cycle_reg : 1'b0;
            if (state_reg == kvts_pkg::ST_DONE)
                ovalid_reg <= 1'b1;
            else if (out_valid && out_ready)
                ovalid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            t_reg    <= key_time;
            st_reg   <= (cmd == kvts_pkg::CMD_APPEND) && (count_reg >= CW'(MAX_KEYS));
            ox_reg   <= '0;
            oy_reg   <= '0;
            oz_reg   <= '0;
        end
        if (state_reg == kvts_pkg::ST_SCAN && sub_cycle_reg)
        begin
            nxt_reg <= rd_reg;
            prv_reg <= rd_reg;
            if (!found_next && idx_reg >= count_reg)
            begin
                if (count_reg == '0)
                begin
                    ox_reg <= kind_reg ? kvts_pkg::ONE_Q16 : '0;
                    oy_reg <= kind_reg ? kvts_pkg::ONE_Q16 : '0;
                    oz_reg <= kind_reg ? kvts_pkg::ONE_Q16 : '0;
                end
                else
                begin
                    // last key read on the previous check
                    ox_reg <= prv_reg[95:64];
                    oy_reg <= prv_reg[63:32];
                    oz_reg <= prv_reg[31:0];
                end
            end
        end
        if (state_reg == kvts_pkg::ST_PREV && sub_cycle_reg)
            prv_reg <= rd_reg;
        if (state_reg == kvts_pkg::ST_MUL && sub_cycle_reg)
        begin
            case (comp_reg)
                2'd0:    ox_reg <= ly;
                2'd1:    oy_reg <= ly;
                default: oz_reg <= ly;
            endcase
        end
    end

    assign out_valid = ovalid_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;
    assign out_z     = oz_reg;
    assign status    = st_reg;
endmodule
